@@ sv/rpe_pkg.sv @@
package rpe_pkg;

  localparam int NUM_ELEMENTS = 256;
  localparam int EW = $clog2(NUM_ELEMENTS);
  localparam int PW = EW + 1;

  localparam logic [1:0] FUNC_MARK   = 2'd0;
  localparam logic [1:0] FUNC_SPLIT  = 2'd1;
  localparam logic [1:0] FUNC_QSET   = 2'd2;
  localparam logic [1:0] FUNC_QELEM  = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] element;
    logic [7:0] set_id;
  } in_item_t;

  typedef struct packed {
    logic [8:0] set_size;
    logic [7:0] set_index;
    logic [7:0] element_out;
    logic       element_valid;
    logic       marks_none;
  } out_item_t;

  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_RD_ELEM  = 4'd1;
  localparam logic [3:0] OP_RD_SET   = 4'd2;
  localparam logic [3:0] OP_RD_ORD_M = 4'd3;
  localparam logic [3:0] OP_MARK_WR  = 4'd4;
  localparam logic [3:0] OP_MARK_WR2 = 4'd5;
  localparam logic [3:0] OP_SPLIT_SET = 4'd6;
  localparam logic [3:0] OP_RELABEL  = 4'd7;
  localparam logic [3:0] OP_RD_ORD_Q = 4'd8;
  localparam logic [3:0] OP_DONE     = 4'd9;
  localparam logic [3:0] OP_CLEAR    = 4'd10;
  localparam logic [3:0] OP_LOAD     = 4'd11;
  localparam logic [3:0] OP_RD_ORD_R = 4'd12;
  localparam logic [3:0] OP_FIX_MARK = 4'd13;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic mark_skip;
    logic split_go;
    logic split_fix;
    logic relabel_last;
    logic qelem_read;
  } status_t;

endpackage

@@ sv/rpe_ram.sv @@
module rpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/rpe_datapath.sv @@
module rpe_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  rpe_pkg::cmd_t      cmd,
  input  rpe_pkg::in_item_t  in_data,
  output rpe_pkg::status_t   status,
  output rpe_pkg::out_item_t out_data
);

  localparam int EW = rpe_pkg::EW;
  localparam int PW = rpe_pkg::PW;
  localparam logic [PW-1:0] NE = PW'(rpe_pkg::NUM_ELEMENTS);

  rpe_pkg::in_item_t item_r;
  logic [EW-1:0] clr_r, clr_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic [EW-1:0] s_r, s_nxt;
  logic [EW-1:0] p_r, p_nxt;
  logic [PW-1:0] m_r, m_nxt;
  logic [PW-1:0] st_r, st_nxt;
  logic [PW-1:0] sp_r, sp_nxt;
  logic [PW-1:0] i_r, i_nxt;
  logic [EW-1:0] other_r, other_nxt;
  logic          made_r, made_nxt;

  logic          ord_we, pos_we, eset_we, sa_we, me_we, so_we;
  logic [EW-1:0] ord_wa, pos_wa, eset_wa, set_wa;
  logic [EW-1:0] ord_wd, pos_wd, eset_wd;
  logic [PW-1:0] sa_wd, me_wd, so_wd;
  logic [EW-1:0] ord_ra, elem_ra, set_ra;
  logic [EW-1:0] ord_rd, pos_rd, eset_rd;
  logic [PW-1:0] sa_rd, me_rd, so_rd;

  rpe_ram #(.WIDTH(EW), .DEPTH(rpe_pkg::NUM_ELEMENTS)) u_ord (
    .clk, .we(ord_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra), .rdata(ord_rd));
  rpe_ram #(.WIDTH(EW), .DEPTH(rpe_pkg::NUM_ELEMENTS)) u_pos (
    .clk, .we(pos_we), .waddr(pos_wa), .wdata(pos_wd), .raddr(elem_ra), .rdata(pos_rd));
  rpe_ram #(.WIDTH(EW), .DEPTH(rpe_pkg::NUM_ELEMENTS)) u_eset (
    .clk, .we(eset_we), .waddr(eset_wa), .wdata(eset_wd), .raddr(elem_ra), .rdata(eset_rd));
  rpe_ram #(.WIDTH(PW), .DEPTH(rpe_pkg::NUM_ELEMENTS)) u_sa (
    .clk, .we(sa_we), .waddr(set_wa), .wdata(sa_wd), .raddr(set_ra), .rdata(sa_rd));
  rpe_ram #(.WIDTH(PW), .DEPTH(rpe_pkg::NUM_ELEMENTS)) u_me (
    .clk, .we(me_we), .waddr(set_wa), .wdata(me_wd), .raddr(set_ra), .rdata(me_rd));
  rpe_ram #(.WIDTH(PW), .DEPTH(rpe_pkg::NUM_ELEMENTS)) u_so (
    .clk, .we(so_we), .waddr(set_wa), .wdata(so_wd), .raddr(set_ra), .rdata(so_rd));

  logic set_ok;
  logic [PW-1:0] me_eff;
  logic [PW-1:0] nxt_pos;
  assign set_ok = {1'b0, item_r.set_id} < cnt_r;
  assign me_eff = (me_rd == so_rd) ? sa_rd : me_rd;
  assign nxt_pos = {1'b0, p_r} + 1'b1;

  function automatic logic [EW-1:0] nxt_ord_addr(input logic [PW-1:0] v);
    logic [PW-1:0] t;
    t = v + 1'b1;
    return t[EW-1:0];
  endfunction

  always_comb begin
    ord_we = 1'b0; pos_we = 1'b0; eset_we = 1'b0;
    sa_we = 1'b0; me_we = 1'b0; so_we = 1'b0;
    ord_wa = '0; pos_wa = '0; eset_wa = '0; set_wa = '0;
    ord_wd = '0; pos_wd = '0; eset_wd = '0;
    sa_wd = '0; me_wd = '0; so_wd = '0;
    ord_ra = '0; elem_ra = '0; set_ra = '0;
    clr_nxt = clr_r; cnt_nxt = cnt_r;
    s_nxt = s_r; p_nxt = p_r; m_nxt = m_r; st_nxt = st_r; sp_nxt = sp_r;
    i_nxt = i_r; other_nxt = other_r; made_nxt = made_r;
    case (cmd.op)
      rpe_pkg::OP_CLEAR: begin
        ord_we = 1'b1; pos_we = 1'b1; eset_we = 1'b1;
        sa_we = 1'b1; me_we = 1'b1; so_we = 1'b1;
        ord_wa = clr_r; pos_wa = clr_r; eset_wa = clr_r; set_wa = clr_r;
        ord_wd = clr_r; pos_wd = clr_r;
        so_wd = (clr_r == '0) ? NE : '0;
        clr_nxt = clr_r + 1'b1;
        cnt_nxt = PW'(1);
      end
      rpe_pkg::OP_LOAD: begin
        elem_ra = in_data.element;
        set_ra = in_data.set_id;
        made_nxt = 1'b0;
      end
      rpe_pkg::OP_RD_ELEM: begin
        s_nxt = eset_rd;
        p_nxt = pos_rd;
        set_ra = eset_rd;
      end
      rpe_pkg::OP_RD_SET: begin
        m_nxt = me_rd;
        sp_nxt = so_rd;
        ord_ra = me_rd[EW-1:0];
      end
      rpe_pkg::OP_RD_ORD_M: begin
        other_nxt = ord_rd;
      end
      rpe_pkg::OP_MARK_WR: begin
        ord_we = 1'b1; ord_wa = p_r; ord_wd = other_r;
        pos_we = 1'b1; pos_wa = other_r; pos_wd = p_r;
        set_wa = s_r; me_we = 1'b1; me_wd = m_r + 1'b1;
        sa_we = 1'b0;
      end
      rpe_pkg::OP_MARK_WR2: begin
        ord_we = 1'b1; ord_wa = m_r[EW-1:0]; ord_wd = item_r.element;
        pos_we = 1'b1; pos_wa = item_r.element; pos_wd = m_r[EW-1:0];
      end
      rpe_pkg::OP_FIX_MARK: begin
        set_wa = item_r.set_id; me_we = 1'b1; me_wd = me_eff;
      end
      rpe_pkg::OP_SPLIT_SET: begin
        st_nxt = sa_rd; m_nxt = me_eff; i_nxt = sa_rd;
        s_nxt = cnt_r[EW-1:0];
        made_nxt = 1'b1;
        set_wa = cnt_r[EW-1:0];
        sa_we = 1'b1; sa_wd = sa_rd;
        me_we = 1'b1; me_wd = sa_rd;
        so_we = 1'b1; so_wd = me_eff;
        ord_ra = sa_rd[EW-1:0];
      end
      rpe_pkg::OP_RELABEL: begin
        set_wa = item_r.set_id;
        sa_we = (i_r == st_r); sa_wd = m_r;
        me_we = (i_r == st_r); me_wd = m_r;
        eset_we = 1'b1; eset_wa = ord_rd; eset_wd = s_r;
        i_nxt = i_r + 1'b1;
        ord_ra = nxt_ord_addr(i_r);
        if (i_r + 1'b1 == m_r) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      rpe_pkg::OP_RD_ORD_Q: begin
        set_ra = s_r;
        sp_nxt = sa_rd; st_nxt = so_rd; m_nxt = me_rd;
        ord_ra = (item_r.func == rpe_pkg::FUNC_QSET) ? sa_rd[EW-1:0] : nxt_pos[EW-1:0];
        if (item_r.func == rpe_pkg::FUNC_QELEM) begin
          st_nxt = so_rd;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      cnt_r <= PW'(1);
    end else begin
      clr_r <= clr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (cmd.op == rpe_pkg::OP_LOAD) begin
      item_r <= in_data;
    end
    s_r <= s_nxt; p_r <= p_nxt; m_r <= m_nxt; st_r <= st_nxt; sp_r <= sp_nxt;
    i_r <= i_nxt; other_r <= other_nxt; made_r <= made_nxt;
  end

  always_comb begin
    status.clear_done = (clr_r == EW'(rpe_pkg::NUM_ELEMENTS - 1));
    status.mark_skip = ({1'b0, p_r} < me_rd) || (me_rd >= NE);
    status.split_go = set_ok && (me_eff != sa_rd) && (cnt_r < NE);
    status.split_fix = set_ok;
    status.relabel_last = (i_r + 1'b1 >= m_r);
    status.qelem_read = ({1'b0, item_r.element} < NE);
  end

  always_comb begin
    out_data = '0;
    case (item_r.func)
      rpe_pkg::FUNC_SPLIT: begin
        if (made_r) begin
          out_data.set_size = m_r - st_r;
          out_data.set_index = s_r;
        end
      end
      rpe_pkg::FUNC_QSET: begin
        if (set_ok) begin
          out_data.set_size = st_r - sp_r;
          out_data.element_out = (sp_r < st_r) ? ord_rd : '0;
          out_data.element_valid = (sp_r < st_r);
          out_data.marks_none = (m_r == sp_r);
        end else begin
          out_data.marks_none = 1'b1;
        end
      end
      rpe_pkg::FUNC_QELEM: begin
        out_data.set_index = s_r;
        out_data.element_out = ((nxt_pos < st_r) && (nxt_pos < NE)) ? ord_rd : '0;
        out_data.element_valid = (nxt_pos < st_r) && (nxt_pos < NE);
      end
      default: ;
    endcase
  end

endmodule

@@ sv/rpe_ctrl.sv @@
module rpe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       func,
  input  rpe_pkg::status_t status,
  output rpe_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             out_valid
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ELEM  = 4'd2;
  localparam logic [3:0] S_SET   = 4'd3;
  localparam logic [3:0] S_ORDM  = 4'd4;
  localparam logic [3:0] S_MWR   = 4'd5;
  localparam logic [3:0] S_MWR2  = 4'd6;
  localparam logic [3:0] S_SPL   = 4'd7;
  localparam logic [3:0] S_REL   = 4'd8;
  localparam logic [3:0] S_FIX   = 4'd9;
  localparam logic [3:0] S_QSET  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd12;
  localparam logic [3:0] S_QE2   = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [1:0] func_r, func_nxt;

  always_comb begin
    state_nxt = state_r;
    func_nxt = func_r;
    cmd.op = rpe_pkg::OP_NONE;
    out_valid = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.op = rpe_pkg::OP_CLEAR;
        if (status.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.op = rpe_pkg::OP_LOAD;
          func_nxt = func;
          case (func)
            rpe_pkg::FUNC_MARK:  state_nxt = S_ELEM;
            rpe_pkg::FUNC_SPLIT: state_nxt = S_SPL;
            rpe_pkg::FUNC_QSET:  state_nxt = S_QSET;
            default:             state_nxt = S_ELEM;
          endcase
        end
      end
      S_ELEM: begin
        cmd.op = rpe_pkg::OP_RD_ELEM;
        if (func_r == rpe_pkg::FUNC_MARK && !status.qelem_read) begin
          state_nxt = S_OUT;
        end else if (func_r == rpe_pkg::FUNC_QELEM && !status.qelem_read) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = (func_r == rpe_pkg::FUNC_MARK) ? S_SET : S_QE2;
        end
      end
      S_SET: begin
        if (status.mark_skip) begin
          state_nxt = S_OUT;
        end else begin
          cmd.op = rpe_pkg::OP_RD_SET;
          state_nxt = S_ORDM;
        end
      end
      S_ORDM: begin
        cmd.op = rpe_pkg::OP_RD_ORD_M;
        state_nxt = S_MWR;
      end
      S_MWR: begin
        cmd.op = rpe_pkg::OP_MARK_WR;
        state_nxt = S_MWR2;
      end
      S_MWR2: begin
        cmd.op = rpe_pkg::OP_MARK_WR2;
        state_nxt = S_OUT;
      end
      S_SPL: begin
        if (status.split_go) begin
          cmd.op = rpe_pkg::OP_SPLIT_SET;
          state_nxt = S_REL;
        end else if (status.split_fix) begin
          cmd.op = rpe_pkg::OP_FIX_MARK;
          state_nxt = S_FIX;
        end else begin
          state_nxt = S_FIX;
        end
      end
      S_REL: begin
        cmd.op = rpe_pkg::OP_RELABEL;
        if (status.relabel_last) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        cmd.op = rpe_pkg::OP_DONE;
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      S_QSET, S_QE2: begin
        cmd.op = rpe_pkg::OP_RD_ORD_Q;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.op = rpe_pkg::OP_DONE;
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      func_r <= rpe_pkg::FUNC_MARK;
    end else begin
      state_r <= state_nxt;
      func_r <= func_nxt;
    end
  end

endmodule

@@ sv/refinable_partition_engine.sv @@
// A mark reads the element, its set and the order table, then writes the swap; an element
// already marked skips straight to the result. A split relabels each member of the new set.
// One item at a time: busy stays high through the strobe cycle, so a new item is taken only
// after the result of the last one.
// Result shows on out_* for one cycle with out_valid; the receiver cannot stall.
// Synchronous active-low reset starts a clearing pass over all 256 table entries with busy high.
module refinable_partition_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rpe_pkg::in_item_t  in_data,
  output logic               out_valid,
  output rpe_pkg::out_item_t out_data
);

  rpe_pkg::cmd_t    cmd;
  rpe_pkg::status_t status;

  rpe_ctrl u_ctrl (
    .clk, .rst_n, .start, .func(in_data.func), .status, .cmd, .busy, .out_valid);

  rpe_datapath u_dp (
    .clk, .rst_n, .cmd, .in_data, .status, .out_data);

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int ITEMS = 1600;
  localparam int QUIET_TAIL = 200;
  localparam int WATCHDOG_LIMIT = 3000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  rpe_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  rpe_pkg::out_item_t out_data;

  refinable_partition_engine dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [7:0] part_order [rpe_pkg::NUM_ELEMENTS];
  logic [7:0] part_pos [rpe_pkg::NUM_ELEMENTS];
  logic [7:0] part_owner [rpe_pkg::NUM_ELEMENTS];
  logic [8:0] blk_first [rpe_pkg::NUM_ELEMENTS];
  logic [8:0] blk_mark_end [rpe_pkg::NUM_ELEMENTS];
  logic [8:0] blk_stop [rpe_pkg::NUM_ELEMENTS];
  logic [8:0] blk_total;

  rpe_pkg::out_item_t pending_results [$];
  rpe_pkg::out_item_t typed_result;
  bit        use_typed = 1'b0;
  int        errors = 0;
  int        sent = 0;
  int        returned = 0;
  int        splits_made = 0;
  int        idle_cycles = 0;

  function automatic void clear_partition();
    for (int i = 0; i < rpe_pkg::NUM_ELEMENTS; i++) begin
      part_order[i] = i[7:0];
      part_pos[i] = i[7:0];
      part_owner[i] = '0;
      blk_first[i] = '0;
      blk_mark_end[i] = '0;
      blk_stop[i] = '0;
    end
    blk_stop[0] = 9'(rpe_pkg::NUM_ELEMENTS);
    blk_total = 9'd1;
  endfunction

  function automatic rpe_pkg::out_item_t partition_step(rpe_pkg::in_item_t it);
    rpe_pkg::out_item_t r;
    logic [7:0] s;
    logic [8:0] p;
    logic [8:0] m;
    logic [8:0] nxt;
    logic [7:0] other;
    logic [7:0] ns;
    r = '0;
    case (it.func)
      rpe_pkg::FUNC_MARK: begin
        s = part_owner[it.element];
        p = {1'b0, part_pos[it.element]};
        m = blk_mark_end[s];
        if (!(p < m || m >= rpe_pkg::NUM_ELEMENTS)) begin
          other = part_order[m[7:0]];
          part_order[p[7:0]] = other;
          part_pos[other] = p[7:0];
          part_order[m[7:0]] = it.element;
          part_pos[it.element] = m[7:0];
          blk_mark_end[s] = m + 9'd1;
        end
      end
      rpe_pkg::FUNC_SPLIT: begin
        s = it.set_id;
        if ({1'b0, s} < blk_total) begin
          if (blk_mark_end[s] == blk_stop[s]) blk_mark_end[s] = blk_first[s];
          if (blk_mark_end[s] != blk_first[s] && blk_total < rpe_pkg::NUM_ELEMENTS) begin
            ns = blk_total[7:0];
            blk_first[ns] = blk_first[s];
            blk_mark_end[ns] = blk_first[s];
            blk_stop[ns] = blk_mark_end[s];
            blk_first[s] = blk_mark_end[s];
            for (int i = blk_first[ns]; i < blk_stop[ns]; i++)
              part_owner[part_order[i]] = ns;
            blk_total = blk_total + 9'd1;
            r.set_index = ns;
            r.set_size = blk_stop[ns] - blk_first[ns];
          end
        end
      end
      rpe_pkg::FUNC_QSET: begin
        s = it.set_id;
        if ({1'b0, s} < blk_total) begin
          r.set_size = blk_stop[s] - blk_first[s];
          if (blk_first[s] < blk_stop[s] && blk_first[s] < rpe_pkg::NUM_ELEMENTS) begin
            r.element_out = part_order[blk_first[s][7:0]];
            r.element_valid = 1'b1;
          end
          r.marks_none = (blk_mark_end[s] == blk_first[s]);
        end else begin
          r.marks_none = 1'b1;
        end
      end
      default: begin
        s = part_owner[it.element];
        nxt = {1'b0, part_pos[it.element]} + 9'd1;
        r.set_index = s;
        if (nxt < blk_stop[s] && nxt < rpe_pkg::NUM_ELEMENTS) begin
          r.element_out = part_order[nxt[7:0]];
          r.element_valid = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  initial clear_partition();

  always @(posedge clk) begin
    rpe_pkg::out_item_t pred;
    rpe_pkg::out_item_t want;
    if (rst_n && start && !busy) begin
      pred = partition_step(in_data);
      if (pred.set_size != 0 && in_data.func == rpe_pkg::FUNC_SPLIT) splits_made++;
      pending_results = {pending_results, (use_typed ? typed_result : pred)};
    end
    if (rst_n && out_valid) begin
      returned++;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.set_size != want.set_size) begin
          $error("set_size: expected %0d, got %0d", want.set_size, out_data.set_size);
          errors++;
        end
        if (out_data.set_index != want.set_index) begin
          $error("set_index: expected %0d, got %0d", want.set_index, out_data.set_index);
          errors++;
        end
        if (out_data.element_out != want.element_out) begin
          $error("element_out: expected %0d, got %0d", want.element_out,
                 out_data.element_out);
          errors++;
        end
        if (out_data.element_valid != want.element_valid) begin
          $error("element_valid: expected %0b, got %0b", want.element_valid,
                 out_data.element_valid);
          errors++;
        end
        if (out_data.marks_none != want.marks_none) begin
          $error("marks_none: expected %0b, got %0b", want.marks_none,
                 out_data.marks_none);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((rst_n && start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic transfer(rpe_pkg::in_item_t it, bit typed, rpe_pkg::out_item_t want,
                          bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    use_typed <= typed;
    typed_result <= want;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  function automatic rpe_pkg::in_item_t make_item(logic [1:0] f, int e, int s);
    rpe_pkg::in_item_t it;
    it.func = f;
    it.element = e[7:0];
    it.set_id = s[7:0];
    return it;
  endfunction

  function automatic rpe_pkg::out_item_t make_result(int sz, int idx, int eo, bit ev, bit mn);
    rpe_pkg::out_item_t r;
    r.set_size = sz[8:0];
    r.set_index = idx[7:0];
    r.element_out = eo[7:0];
    r.element_valid = ev;
    r.marks_none = mn;
    return r;
  endfunction

  typedef struct {
    rpe_pkg::in_item_t  it;
    bit                 typed;
    rpe_pkg::out_item_t want;
  } stim_row_t;

  stim_row_t directed [$];

  initial begin
    rpe_pkg::in_item_t it;
    logic [7:0] s;
    int         k;
    int         span;
    bit         gaps;

    directed = '{
      '{make_item(rpe_pkg::FUNC_QSET, 0, 0), 1, make_result(256, 0, 0, 1, 1)},
      '{make_item(rpe_pkg::FUNC_QSET, 0, 255), 1, make_result(0, 0, 0, 0, 1)},
      '{make_item(rpe_pkg::FUNC_QELEM, 255, 0), 1, make_result(0, 0, 0, 0, 0)},
      '{make_item(rpe_pkg::FUNC_QELEM, 0, 0), 1, make_result(0, 0, 1, 1, 0)},
      '{make_item(rpe_pkg::FUNC_SPLIT, 0, 0), 1, make_result(0, 0, 0, 0, 0)},
      '{make_item(rpe_pkg::FUNC_SPLIT, 0, 7), 1, make_result(0, 0, 0, 0, 0)},
      '{make_item(rpe_pkg::FUNC_MARK, 0, 0), 1, make_result(0, 0, 0, 0, 0)},
      '{make_item(rpe_pkg::FUNC_MARK, 255, 255), 1, make_result(0, 0, 0, 0, 0)},
      '{make_item(rpe_pkg::FUNC_MARK, 255, 0), 1, make_result(0, 0, 0, 0, 0)},
      '{make_item(rpe_pkg::FUNC_QSET, 0, 0), 0, '0},
      '{make_item(rpe_pkg::FUNC_SPLIT, 0, 0), 0, '0},
      '{make_item(rpe_pkg::FUNC_QSET, 0, 1), 0, '0},
      '{make_item(rpe_pkg::FUNC_QELEM, 0, 0), 0, '0},
      '{make_item(rpe_pkg::FUNC_QELEM, 255, 0), 0, '0},
      '{make_item(rpe_pkg::FUNC_MARK, 0, 0), 0, '0},
      '{make_item(rpe_pkg::FUNC_MARK, 255, 0), 0, '0},
      '{make_item(rpe_pkg::FUNC_SPLIT, 0, 1), 0, '0},
      '{make_item(rpe_pkg::FUNC_QSET, 0, 1), 0, '0},
      '{make_item(rpe_pkg::FUNC_MARK, 170, 0), 0, '0},
      '{make_item(rpe_pkg::FUNC_MARK, 85, 0), 0, '0},
      '{make_item(rpe_pkg::FUNC_SPLIT, 0, 0), 0, '0},
      '{make_item(rpe_pkg::FUNC_QELEM, 85, 0), 0, '0},
      '{make_item(rpe_pkg::FUNC_QSET, 0, 2), 0, '0},
      '{make_item(rpe_pkg::FUNC_QSET, 0, 0), 0, '0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) transfer(directed[i].it, directed[i].typed, directed[i].want, 1'b1);
    hold_until_drained();

    while (sent < ITEMS) begin
      gaps = (sent < ITEMS - QUIET_TAIL);
      if (sent > ITEMS / 2 && sent < ITEMS / 2 + 8) hold_until_drained();
      if ($urandom_range(0, 9) < 6) begin
        // mark up to 6 members of one set (sometimes all of them), maybe query it, then split it
        s = part_owner[$urandom_range(0, rpe_pkg::NUM_ELEMENTS - 1)];
        span = blk_stop[s] - blk_first[s];
        k = $urandom_range(1, (span < 6) ? span : 6);
        if ($urandom_range(0, 7) == 0) k = span;
        for (int j = 0; j < k; j++) begin
          it = make_item(rpe_pkg::FUNC_MARK,
                         int'(part_order[blk_first[s] + $urandom_range(0, span - 1)]),
                         $urandom_range(0, 255));
          transfer(it, 1'b0, '0, gaps);
        end
        if ($urandom_range(0, 3) == 0)
          transfer(make_item(rpe_pkg::FUNC_QSET, $urandom_range(0, 255), int'(s)),
                   1'b0, '0, gaps);
        transfer(make_item(rpe_pkg::FUNC_SPLIT, $urandom_range(0, 255), int'(s)),
                 1'b0, '0, gaps);
      end else begin
        it.func = 2'($urandom_range(0, 3));
        it.element = 8'($urandom_range(0, 255));
        it.set_id = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, blk_total - 1));
        transfer(it, 1'b0, '0, gaps);
      end
    end
    start <= 1'b0;

    do @(posedge clk); while (pending_results.size() != 0);
    repeat (300) @(posedge clk);

    $display("Sent %0d commands, checked %0d results; %0d splits made, %0d sets in the end.",
             sent, returned, splits_made, blk_total);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
